/* hdl/gbr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared widths, register codes and division tables of the renormalized
// 3x3 Gaussian blur unit.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int PIX_W = 8;

	// configuration port
	localparam int WREG_W     = 12;
	localparam int HREG_W     = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// line buffer word: row-2 pixel above row-1 pixel
	localparam int LB_W = 2 * PIX_W;

	// weighted sum and weight
	localparam int SUM_W       = PIX_W + 4;
	localparam int WT_W        = 5;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 23;

	localparam logic [2:0] KERNEL [3][3] = '{
		'{3'd1, 3'd2, 3'd1},
		'{3'd2, 3'd4, 3'd2},
		'{3'd1, 3'd2, 3'd1}
	};

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;   // [row][col], col 2 newest

	// one input pixel's pending results and its window
	typedef struct packed {
		win_t             win;
		logic [3:0]       pend;
		logic             up2_ok;
		logic             up1_ok;
		logic             left2_ok;
		logic             left1_ok;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} job_t;

	// ceil(2^RECIP_SHIFT / weight); exact for every sum the kernel can give
	function automatic logic [RECIP_W-1:0] recip(input logic [WT_W-1:0] wt);
		logic [RECIP_W-1:0] r;
		case (wt)
			5'd16:   r = 23'd1048576;
			5'd12:   r = 23'd1398102;
			5'd9:    r = 23'd1864136;
			5'd8:    r = 23'd2097152;
			5'd6:    r = 23'd2796203;
			5'd4:    r = 23'd4194304;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/gbr_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr channel interfaces
// Valid/ready channels for input pixels, blurred results and register writes.
// ----------------------------------------------------------------------------
interface gbr_pix_if;
	import gbr_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gbr_res_if;
	import gbr_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic             last_of_image;
	modport source (output valid, output pixel_out, output out_col, output out_row,
		output last_of_image, input ready);
	modport sink   (input valid, input pixel_out, input out_col, input out_row,
		input last_of_image, output ready);
endinterface

interface gbr_cfg_if;
	import gbr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/gaussian_blur_3x3_renormalized_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_renormalized_unit
// 3x3 Gaussian blur over a raster pixel stream, border taps dropped and the
// sum divided by the weight of the taps that lie inside the image.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+---------------
//  pixels   | in  | pixel_in                                  | valid & ready
//  results  | out | pixel_out, out_col, out_row, last_of_image| valid & ready
//  cfg      | in  | index, data (0 image_width, 1 image_height)| valid & ready
//
// One pixel is taken per cycle while it causes at most one result and the
// results channel does not stall; a pixel that causes n results (row ends,
// last row) holds the input while the single blur/divide unit emits them, one
// a cycle when not stalled. Results pass s1, s2, s3 and the output register.
// The line buffer RAM needs no clearing after reset; cfg is always ready.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_renormalized_unit (
	input wire logic   clk,
	input wire logic   arst_n,
	gbr_pix_if.sink    pixels,
	gbr_res_if.source  results,
	gbr_cfg_if.sink    cfg
);
	import gbr_pkg::*;

	function automatic logic [COL_W-1:0] width_last(input logic [WREG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > WREG_W'(MAX_WIDTH)) begin
			r = COL_W'(MAX_WIDTH - 1);
		end else begin
			r = COL_W'(v - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] height_last(input logic [HREG_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > HREG_W'(MAX_HEIGHT)) begin
			r = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			r = ROW_W'(v - 1'b1);
		end
		return r;
	endfunction

	// ---------------- configuration ----------------
	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hlast_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= COL_W'(WIDTH_RESET - 1);
			hlast_q <= ROW_W'(HEIGHT_RESET - 1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  wlast_q <= width_last(cfg.data[WREG_W-1:0]);
				REG_IMAGE_HEIGHT: hlast_q <= height_last(cfg.data[HREG_W-1:0]);
				default: ;
			endcase
		end
	end

	// ---------------- accept stage ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             eol;
	logic             last_row;
	logic             s1_go;

	// s1: line buffer data is out of the RAM
	logic             v_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [3:0]       pend_s1;
	logic             up2_ok_s1, up1_ok_s1, left2_ok_s1, left1_ok_s1;
	logic             fwd_s1;
	pix_t             fwd_one_s1, fwd_two_s1;

	logic [LB_W-1:0]  lb_rdata;
	pix_t             up1, up2;
	win_t             win_q, win_next;

	assign eol           = col_q >= wlast_q;
	assign last_row      = row_q >= hlast_q;
	assign pixels.ready  = !v_s1 || s1_go;
	assign accept        = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixels.ready) begin
			v_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixels.pixel_in;
			col_s1      <= col_q;
			row_s1      <= row_q;
			pend_s1     <= {last_row && eol, last_row && (col_q != '0),
				(row_q != '0) && eol, (row_q != '0) && (col_q != '0)};
			up2_ok_s1   <= row_q > ROW_W'(1);
			up1_ok_s1   <= row_q != '0;
			left2_ok_s1 <= col_q > COL_W'(1);
			left1_ok_s1 <= col_q != '0;
			// same column written back this cycle: the RAM read returns old data
			fwd_s1      <= v_s1 && s1_go && (col_s1 == col_q);
			fwd_one_s1  <= pix_s1;
			fwd_two_s1  <= up1;
		end
	end

	gbr_ram #(
		.WIDTH(LB_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata ({up1, pix_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (lb_rdata)
	);

	assign up1 = fwd_s1 ? fwd_one_s1 : lb_rdata[PIX_W-1:0];
	assign up2 = fwd_s1 ? fwd_two_s1 : lb_rdata[LB_W-1:PIX_W];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r][0] = win_q[r][1];
			win_next[r][1] = win_q[r][2];
		end
		win_next[0][2] = up2;
		win_next[1][2] = up1;
		win_next[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go) begin
			win_q <= win_next;
		end
	end

	// ---------------- s2: result sequencer ----------------
	logic             job_v_s2;
	job_t             job_s2;
	logic [1:0]       sel;
	logic [3:0]       pend_left;
	logic             job_last;
	logic             issue;
	logic             s2_can_load;
	logic             rc_hi, cc_hi;
	logic             up_ok, down_ok, left_ok, right_ok;
	logic [SUM_W-1:0] sum_c;
	logic [WT_W-1:0]  wt_c;

	// s3: divide
	logic             v_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [WT_W-1:0]  wt_s3;
	logic [COL_W-1:0] col_s3;
	logic [ROW_W-1:0] row_s3;
	logic             last_s3;
	logic             s3_free;

	// output register
	logic             out_v_q;
	pix_t             out_pix_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             out_last_q;
	logic             out_take;

	assign out_take = !out_v_q || results.ready;
	assign s3_free  = !v_s3 || out_take;

	always_comb begin
		if (job_s2.pend[0]) begin
			sel = 2'd0;
		end else if (job_s2.pend[1]) begin
			sel = 2'd1;
		end else if (job_s2.pend[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	assign pend_left   = job_s2.pend & ~(4'b0001 << sel);
	assign job_last    = pend_left == '0;
	assign issue       = job_v_s2 && s3_free;
	assign s2_can_load = !job_v_s2 || (issue && job_last);
	assign s1_go       = v_s1 && ((pend_s1 == '0) || s2_can_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s2 <= 1'b0;
		end else if (s1_go && (pend_s1 != '0)) begin
			job_v_s2 <= 1'b1;
		end else if (issue && job_last) begin
			job_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (pend_s1 != '0)) begin
			job_s2.win      <= win_next;
			job_s2.pend     <= pend_s1;
			job_s2.up2_ok   <= up2_ok_s1;
			job_s2.up1_ok   <= up1_ok_s1;
			job_s2.left2_ok <= left2_ok_s1;
			job_s2.left1_ok <= left1_ok_s1;
			job_s2.col      <= col_s1;
			job_s2.row      <= row_s1;
		end else if (issue) begin
			job_s2.pend <= pend_left;
		end
	end

	// centre in window row/col 1 or 2; bottom row and right column centres
	// have nothing below or to the right
	assign rc_hi    = sel[1];
	assign cc_hi    = sel[0];
	assign up_ok    = rc_hi ? job_s2.up1_ok : job_s2.up2_ok;
	assign down_ok  = !rc_hi;
	assign left_ok  = cc_hi ? job_s2.left1_ok : job_s2.left2_ok;
	assign right_ok = !cc_hi;

	always_comb begin
		logic [1:0] rr;
		logic [1:0] cc;
		logic       en;
		sum_c = '0;
		wt_c  = '0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				rr = 2'(dy) + {1'b0, rc_hi};
				cc = 2'(dx) + {1'b0, cc_hi};
				en = (dy != 0 || up_ok) && (dy != 2 || down_ok) &&
					(dx != 0 || left_ok) && (dx != 2 || right_ok);
				if (en && rr != 2'd3 && cc != 2'd3) begin
					sum_c = sum_c + SUM_W'(job_s2.win[rr][cc]) * SUM_W'(KERNEL[dy][dx]);
					wt_c  = wt_c + WT_W'(KERNEL[dy][dx]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s3  <= sum_c;
			wt_s3   <= wt_c;
			col_s3  <= cc_hi ? job_s2.col : job_s2.col - 1'b1;
			row_s3  <= rc_hi ? job_s2.row : job_s2.row - 1'b1;
			last_s3 <= sel == 2'd3;
		end
	end

	// ---------------- divide by weight, output register ----------------
	logic [SUM_W+RECIP_W-1:0] prod;

	assign prod = (SUM_W + RECIP_W)'(sum_s3) * (SUM_W + RECIP_W)'(recip(wt_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_take) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && v_s3) begin
			out_pix_q  <= prod[RECIP_SHIFT +: PIX_W];
			out_col_q  <= col_s3;
			out_row_q  <= row_s3;
			out_last_q <= last_s3;
		end
	end

	assign results.valid         = out_v_q;
	assign results.pixel_out     = out_pix_q;
	assign results.out_col       = out_col_q;
	assign results.out_row       = out_row_q;
	assign results.last_of_image = out_last_q;

endmodule
`default_nettype wire

/* hdl/gbr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* tb/sv/tb_gaussian_blur_3x3_renormalized_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_renormalized_unit
// Streams whole images through the blur unit. Directed images cover border
// weights, single row/column frames, saturated line widths and heights and
// geometry changes in the middle of a frame. Random small frames follow.
// Every result is compared against a local line-buffer model of the blur.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_renormalized_unit;
	import gbr_pkg::*;

	typedef enum logic {FILL_RANDOM, FILL_MAX} fill_t;

	typedef struct {
		pix_t             value;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} blurred_pix_t;

	localparam int unsigned TAP_WEIGHT [3][3] = '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}};

	logic clk;
	logic arst_n;

	gbr_pix_if pixels ();
	gbr_res_if results ();
	gbr_cfg_if cfg ();

	gaussian_blur_3x3_renormalized_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixels),
		.results (results),
		.cfg     (cfg)
	);

	// blur model state
	pix_t              line_prev1 [MAX_WIDTH];
	pix_t              line_prev2 [MAX_WIDTH];
	pix_t              win [3][3];   // [row: r-2, r-1, r][col: c-2, c-1, c]
	int unsigned       scan_col;
	int unsigned       scan_row;
	logic [WREG_W-1:0] width_reg;
	logic [HREG_W-1:0] height_reg;

	blurred_pix_t blurred_due [$];
	int unsigned  mismatch_count;
	int unsigned  pixels_sent;
	int unsigned  rdy_hold;
	bit           steady;

	always #5 clk = ~clk;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 11) == 0) return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic pix_t weighted_mean(int rc, int cc, bit up_ok, bit down_ok,
			bit left_ok, bit right_ok);
		int unsigned acc;
		int unsigned wsum;
		int r;
		int c;
		acc = 0;
		wsum = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			if ((dy < 0 && !up_ok) || (dy > 0 && !down_ok)) continue;
			for (int dx = -1; dx <= 1; dx++) begin
				if ((dx < 0 && !left_ok) || (dx > 0 && !right_ok)) continue;
				r = rc + dy;
				c = cc + dx;
				if (r < 0 || r > 2 || c < 0 || c > 2) continue;
				acc += win[r][c] * TAP_WEIGHT[dy + 1][dx + 1];
				wsum += TAP_WEIGHT[dy + 1][dx + 1];
			end
		end
		if (wsum == 0) return '0;
		return pix_t'(acc / wsum);
	endfunction

	function automatic void push_blurred(pix_t v, int unsigned c, int unsigned r, bit last);
		blurred_due.push_back('{value: v, col: COL_W'(c), row: ROW_W'(r), last: last});
	endfunction

	// take one pixel into the model and queue the blurred pixels it releases
	function automatic void advance_blur(pix_t p);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		pix_t        up1;
		pix_t        up2;
		bit          eol;
		bit          last_row;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		col = scan_col;
		row = scan_row;
		eol = col >= w - 1;
		last_row = row >= h - 1;
		up1 = '0;
		up2 = '0;
		if (col < MAX_WIDTH) begin
			up1 = line_prev1[col];
			up2 = line_prev2[col];
			line_prev2[col] = up1;
			line_prev1[col] = p;
		end
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = p;

		if (row >= 1 && col >= 1)
			push_blurred(weighted_mean(1, 1, row >= 2, 1'b1, col >= 2, 1'b1),
				col - 1, row - 1, 1'b0);
		if (row >= 1 && eol)
			push_blurred(weighted_mean(1, 2, row >= 2, 1'b1, col >= 1, 1'b0),
				col, row - 1, 1'b0);
		if (last_row && col >= 1)
			push_blurred(weighted_mean(2, 1, row >= 1, 1'b0, col >= 2, 1'b1),
				col - 1, row, 1'b0);
		if (last_row && eol)
			push_blurred(weighted_mean(2, 2, row >= 1, 1'b0, col >= 1, 1'b0),
				col, row, 1'b1);

		if (eol) begin
			scan_col = 0;
			scan_row = last_row ? 0 : row + 1;
		end else begin
			scan_col = col + 1;
		end
	endfunction

	// result side: compare each transfer, then pick the next ready
	always @(posedge clk) begin : result_check
		blurred_pix_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (blurred_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result pix=%0d col=%0d row=%0d last=%0b",
							$realtime, results.pixel_out, results.out_col, results.out_row,
							results.last_of_image);
					mismatch_count++;
				end else begin
					want = blurred_due.pop_front();
					if (results.pixel_out !== want.value || results.out_col !== want.col ||
							results.out_row !== want.row || results.last_of_image !== want.last) begin
						if (mismatch_count < 10)
							$display("%0t: mismatch expected pix=%0d col=%0d row=%0d last=%0b, got pix=%0d col=%0d row=%0d last=%0b",
								$realtime, want.value, want.col, want.row, want.last,
								results.pixel_out, results.out_col, results.out_row,
								results.last_of_image);
						mismatch_count++;
					end
				end
			end
			if (rdy_hold > 0) begin
				results.ready <= 1'b0;
				rdy_hold <= rdy_hold - 1;
			end else begin
				results.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					rdy_hold <= pick_gap();
			end
		end
	end

	// hold valid until the transfer; the caller lowers it when a gap follows
	task automatic send_pixel(input pix_t p);
		pixels.valid    <= 1'b1;
		pixels.pixel_in <= p;
		do @(posedge clk); while (!pixels.ready);
		advance_blur(p);
		pixels_sent++;
	endtask

	task automatic pixel_gap();
		int unsigned n;
		if (!steady && $urandom_range(0, 3) == 0) begin
			n = pick_gap();
			pixels.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_run(input int unsigned count, input fill_t fill);
		pix_t p;
		int unsigned sel;
		for (int unsigned i = 0; i < count; i++) begin
			sel = $urandom_range(0, 9);
			if (fill == FILL_MAX || sel == 1) p = '1;
			else if (sel == 0) p = '0;
			else p = pix_t'($urandom_range(0, 255));
			send_pixel(p);
			pixel_gap();
		end
	endtask

	task automatic run_image(input fill_t fill);
		send_run(clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT), fill);
	endtask

	// stop sending, wait for every expected result, then let the pipe empty
	task automatic drain_idle();
		pixels.valid <= 1'b0;
		while (blurred_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// leaves cfg.valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_IMAGE_WIDTH) width_reg = data[WREG_W-1:0];
		else height_reg = data[HREG_W-1:0];
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h);
		drain_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg.valid <= 1'b0;
	endtask

	// border weights and degenerate frames, no idling on either side
	task automatic test_small_frames();
		steady = 1'b1;
		set_geometry(3, 3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_pixel(((r + c) % 2 == 1) ? 8'hFF : 8'h00);
		set_geometry(1, 1);
		run_image(FILL_MAX);
		set_geometry(2, 1);
		run_image(FILL_RANDOM);
		set_geometry(1, 3);
		run_image(FILL_RANDOM);
		steady = 1'b0;
	endtask

	// shrink width and height while a frame is half done
	task automatic test_geometry_change_mid_frame();
		// column counter beyond the new last column ends the row
		set_geometry(6, 4);
		send_run(10, FILL_RANDOM);
		set_geometry(3, 3);
		send_run(4, FILL_RANDOM);
		// row counter beyond the new last row makes it the last row
		set_geometry(4, 5);
		send_run(10, FILL_RANDOM);
		set_geometry(4, 2);
		send_run(2, FILL_RANDOM);
	endtask

	// start a full-width row, then narrow it so the row ends early
	task automatic test_full_width_rows();
		set_geometry(CFG_DATA_W'(MAX_WIDTH), 2);
		send_run(8, FILL_RANDOM);
		set_geometry(4, 2);
		send_run(5, FILL_RANDOM);
	endtask

	// all-ones width saturates, zero height reads as one row
	task automatic test_saturated_width();
		set_geometry('1, 0);
		send_run(12, FILL_RANDOM);
		set_geometry(2, 0);
		send_run(1, FILL_RANDOM);
	endtask

	// zero width reads as one column, all-ones height saturates
	task automatic test_saturated_height();
		set_geometry(0, '1);
		send_run(6, FILL_RANDOM);
		set_geometry(0, 1);
		send_run(1, FILL_RANDOM);
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int unsigned w;
		int unsigned h;
		start = pixels_sent;
		while (pixels_sent - start < 90) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
			h = $urandom_range(0, 6);
			steady = ($urandom_range(0, 4) == 0);
			set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h));
			run_image(FILL_RANDOM);
		end
		steady = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pixels.valid = 1'b0;
		pixels.pixel_in = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		results.ready = 1'b0;
		foreach (line_prev1[i]) begin
			line_prev1[i] = '0;
			line_prev2[i] = '0;
		end
		foreach (win[r, c]) win[r][c] = '0;
		scan_col = 0;
		scan_row = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		mismatch_count = 0;
		pixels_sent = 0;
		rdy_hold = 0;
		steady = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_frames();
		test_geometry_change_mid_frame();
		test_full_width_rows();
		test_saturated_width();
		test_saturated_height();
		test_random_frames();

		drain_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && blurred_due.size() == 0)
			$display("** gaussian_blur_3x3_renormalized_unit: PASSED **");
		else
			$display("** gaussian_blur_3x3_renormalized_unit: FAILED **");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("** gaussian_blur_3x3_renormalized_unit: FAILED **");
		$finish;
	end

endmodule
